// ===== design/assert_macros.svh =====
// assertion macros used by the density core
// no dependencies; include once per compilation unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define GMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define GMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gmd_pkg.sv =====
// shared types, constants and the pow2 table builder for the mixture density core
// no dependencies
package gmd_pkg;

    localparam int MAX_COMPONENTS_DEF = 16;
    localparam int EXP_TABLE_BITS_DEF = 8;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [21:0] T_LIMIT   = 22'h200000;

    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic [31:0] mean_x;
        logic [31:0] mean_y;
        logic [31:0] inv_sigma_x;
        logic [31:0] inv_sigma_y;
        logic [16:0] correlation;
        logic [31:0] peak_scale;
        logic [31:0] exponent_scale;
    } comp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DIVIDE
    } state_t;

    // q30 value of 2^(idx/2^bits), 21 term series; only called with constants
    function automatic logic [31:0] rom_entry(input int idx, input int bits);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        z = (64'(idx) * 64'(LN2_Q30)) >> bits;
        term = 64'd1 << 30;
        sum = term;
        for (int k = 1; k <= 20; k++)
        begin
            term = ((term * z) >> 30) / 64'(k);
            sum = sum + term;
        end
        return sum[31:0];
    endfunction

endpackage

// ===== design/gmd_cell.sv =====
// one component slot of the rotating chain
// depends on gmd_pkg
module gmd_cell
    import gmd_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  comp_t from_next,
    input  logic  load,
    input  comp_t load_data,
    output comp_t comp
);

    comp_t comp_reg;

    always_ff @(posedge clk)
    begin
        priority if (load)
        begin
            comp_reg <= load_data;
        end
        else if (shift)
        begin
            comp_reg <= from_next;
        end
        else
        begin
            comp_reg <= comp_reg;
        end
    end

    assign comp = comp_reg;

endmodule

// ===== design/gmd_term.sv =====
// pipelined evaluation of one weighted gaussian term, 15 register stages
// depends on gmd_pkg
module gmd_term
    import gmd_pkg::*;
#(
    parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  comp_t       comp,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    output logic        out_valid,
    output logic [63:0] term,
    output logic        active
);

    localparam int NST = 15;
    localparam int ROM_SIZE = 1 << EXP_TABLE_BITS;
    localparam int RES = 16 - EXP_TABLE_BITS;
    localparam int YPW = RES + 30;
    localparam int YW = RES + 14;
    localparam int YYW = 2 * YW;
    localparam int YSW = YYW - 31;

    logic [31:0] rom_tab [ROM_SIZE];

    for (genvar g = 0; g < ROM_SIZE; g++)
    begin : g_rom
        assign rom_tab[g] = rom_entry(g, EXP_TABLE_BITS);
    end

    logic [NST-1:0] vld_reg;

    // stage registers
    logic        a_dneg_reg, a_eneg_reg;
    logic [32:0] a_dmag_reg, a_emag_reg;
    logic [31:0] a_ix_reg, a_iy_reg, a_b_reg, a_c_reg;
    logic [16:0] a_rho_reg;
    logic        b_dneg_reg, b_eneg_reg;
    logic [30:0] b_dmag_reg, b_emag_reg;
    logic [31:0] b_b_reg, b_c_reg;
    logic [16:0] b_rho_reg;
    logic [45:0] c_dd_reg, c_ee_reg, c_demag_reg;
    logic        c_deneg_reg;
    logic [31:0] c_b_reg, c_c_reg;
    logic [16:0] c_rho_reg;
    logic [46:0] d_s_reg, d_rt_reg;
    logic        d_rtneg_reg;
    logic [31:0] d_b_reg, d_c_reg;
    logic [46:0] e_fmag_reg;
    logic        e_fneg_reg;
    logic [31:0] e_b_reg, e_c_reg;
    logic [63:0] f_ph_reg;
    logic [31:0] f_pl_reg;
    logic        f_tneg_reg;
    logic [31:0] f_b_reg;
    logic [21:0] g_tmag_reg;
    logic        g_tneg_reg;
    logic [31:0] g_b_reg;
    logic [52:0] h_v_reg;
    logic [31:0] h_b_reg;
    logic [YW-1:0] i_y_reg;
    logic [31:0] i_rom_reg, i_b_reg;
    logic [6:0]  i_sh_reg;
    logic [YW-1:0] j_y_reg;
    logic [YSW-1:0] j_yy_reg;
    logic [31:0] j_rom_reg, j_b_reg;
    logic [6:0]  j_sh_reg;
    logic [31:0] k_p_reg, k_rom_reg, k_b_reg;
    logic [6:0]  k_sh_reg;
    logic [33:0] l_m_reg;
    logic [6:0]  l_sh_reg;
    logic [31:0] l_b_reg;
    logic [63:0] m_e_reg;
    logic [31:0] m_b_reg;
    logic [63:0] n_ph_reg;
    logic [31:0] n_pl_reg;
    logic [63:0] o_term_reg;

    // next values
    logic        a_dneg_next, a_eneg_next;
    logic [32:0] a_dmag_next, a_emag_next;
    logic [30:0] b_dmag_next, b_emag_next;
    logic [45:0] c_dd_next, c_ee_next, c_demag_next;
    logic [46:0] d_s_next, d_rt_next;
    logic [46:0] e_fmag_next;
    logic        e_fneg_next;
    logic [63:0] f_ph_next;
    logic [31:0] f_pl_next;
    logic [21:0] g_tmag_next;
    logic [52:0] h_v_next;
    logic [YW-1:0] i_y_next;
    logic [31:0] i_rom_next;
    logic [YSW-1:0] j_yy_next;
    logic [31:0] k_p_next;
    logic [33:0] l_m_next;
    logic [63:0] m_e_next;
    logic [63:0] n_ph_next;
    logic [31:0] n_pl_next;
    logic [63:0] o_term_next;

    logic [32:0]  dx, dy;
    logic [64:0]  dprod, eprod;
    logic [61:0]  ddp, eep, dep;
    logic [16:0]  rmag;
    logic [62:0]  rp;
    logic [49:0]  s_ext, rt2, fs, fabs;
    logic [31:0]  cmag;
    logic [47:0]  plw;
    logic [63:0]  psum;
    logic [52:0]  lprod;
    logic [YPW-1:0] yprod;
    logic [YYW-1:0] yy;
    logic [63:0]  mm;
    logic [6:0]   sft;
    logic [127:0] wide;
    logic [63:0]  blo;
    logic [64:0]  sum65;

    always_comb
    begin
        // a: offsets from the mean, sign and magnitude
        dx = {pos_x[31], pos_x} - {comp.mean_x[31], comp.mean_x};
        dy = {pos_y[31], pos_y} - {comp.mean_y[31], comp.mean_y};
        a_dneg_next = dx[32];
        a_eneg_next = dy[32];
        a_dmag_next = dx[32] ? (~dx + 33'd1) : dx;
        a_emag_next = dy[32] ? (~dy + 33'd1) : dy;

        // b: scale by reciprocal sigma, clamp to 31 bits
        dprod = 65'(a_dmag_reg) * 65'(a_ix_reg);
        eprod = 65'(a_emag_reg) * 65'(a_iy_reg);
        b_dmag_next = (|dprod[64:47]) ? 31'h7FFFFFFF : dprod[46:16];
        b_emag_next = (|eprod[64:47]) ? 31'h7FFFFFFF : eprod[46:16];

        // c: squares and cross product
        ddp = 62'(b_dmag_reg) * 62'(b_dmag_reg);
        eep = 62'(b_emag_reg) * 62'(b_emag_reg);
        dep = 62'(b_dmag_reg) * 62'(b_emag_reg);
        c_dd_next = ddp[61:16];
        c_ee_next = eep[61:16];
        c_demag_next = dep[61:16];

        // d: correlation term
        rmag = c_rho_reg[16] ? (~c_rho_reg + 17'd1) : c_rho_reg;
        rp = 63'(rmag) * 63'(c_demag_reg);
        d_rt_next = rp[62:16];
        d_s_next = 47'(c_dd_reg) + 47'(c_ee_reg);

        // e: quadratic form, clamped magnitude
        s_ext = {3'b000, d_s_reg};
        rt2 = {2'b00, d_rt_reg, 1'b0};
        fs = d_rtneg_reg ? (s_ext + rt2) : (s_ext - rt2);
        e_fneg_next = fs[49];
        fabs = fs[49] ? (~fs + 50'd1) : fs;
        e_fmag_next = (|fabs[49:47]) ? {47{1'b1}} : fabs[46:0];

        // f: exponent scale products
        cmag = e_c_reg[31] ? (~e_c_reg + 32'd1) : e_c_reg;
        f_ph_next = 64'(cmag) * 64'(e_fmag_reg[46:16]);
        plw = 48'(cmag) * 48'(e_fmag_reg[15:0]);
        f_pl_next = plw[47:16];

        // g: exponent argument, clamped
        psum = f_ph_reg + 64'(f_pl_reg);
        g_tmag_next = (psum > 64'(T_LIMIT)) ? T_LIMIT : psum[21:0];

        // h: to base 2 with a bias that keeps the value positive
        lprod = 53'(g_tmag_reg) * 53'(LOG2E_Q30);
        h_v_next = g_tneg_reg ? ((53'd1 << 52) - lprod) : ((53'd1 << 52) + lprod);

        // i: table lookup and residual times ln2
        yprod = YPW'(h_v_reg[30 +: RES]) * YPW'(LN2_Q30);
        i_y_next = yprod[YPW-1:16];
        i_rom_next = rom_tab[h_v_reg[45 -: EXP_TABLE_BITS]];

        // j: square of residual
        yy = YYW'(i_y_reg) * YYW'(i_y_reg);
        j_yy_next = yy[YYW-1:31];

        // k: polynomial
        k_p_next = 32'h40000000 + 32'(j_y_reg) + 32'(j_yy_reg);

        // l: mantissa
        mm = 64'(k_rom_reg) * 64'(k_p_reg);
        l_m_next = mm[63:30];

        // m: scale by the integer part into q32.32, saturating
        sft = 7'd0;
        wide = '0;
        if (l_sh_reg >= 7'd62)
        begin
            sft = l_sh_reg - 7'd62;
            wide = 128'(l_m_reg) << sft;
            m_e_next = (sft >= 7'd64 || (|wide[127:64])) ? {64{1'b1}} : wide[63:0];
        end
        else
        begin
            m_e_next = 64'(l_m_reg) >> (7'd62 - l_sh_reg);
        end

        // n: peak scale products
        n_ph_next = 64'(m_b_reg) * 64'(m_e_reg[63:32]);
        blo = 64'(m_b_reg) * 64'(m_e_reg[31:0]);
        n_pl_next = blo[63:32];

        // o: saturating sum
        sum65 = {1'b0, n_ph_reg} + 65'(n_pl_reg);
        o_term_next = sum65[64] ? {64{1'b1}} : sum65[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a_dneg_reg  <= a_dneg_next;
        a_eneg_reg  <= a_eneg_next;
        a_dmag_reg  <= a_dmag_next;
        a_emag_reg  <= a_emag_next;
        a_ix_reg    <= comp.inv_sigma_x;
        a_iy_reg    <= comp.inv_sigma_y;
        a_rho_reg   <= comp.correlation;
        a_b_reg     <= comp.peak_scale;
        a_c_reg     <= comp.exponent_scale;

        b_dneg_reg  <= a_dneg_reg;
        b_eneg_reg  <= a_eneg_reg;
        b_dmag_reg  <= b_dmag_next;
        b_emag_reg  <= b_emag_next;
        b_rho_reg   <= a_rho_reg;
        b_b_reg     <= a_b_reg;
        b_c_reg     <= a_c_reg;

        c_dd_reg    <= c_dd_next;
        c_ee_reg    <= c_ee_next;
        c_demag_reg <= c_demag_next;
        c_deneg_reg <= b_dneg_reg ^ b_eneg_reg;
        c_rho_reg   <= b_rho_reg;
        c_b_reg     <= b_b_reg;
        c_c_reg     <= b_c_reg;

        d_s_reg     <= d_s_next;
        d_rt_reg    <= d_rt_next;
        d_rtneg_reg <= c_rho_reg[16] ^ c_deneg_reg;
        d_b_reg     <= c_b_reg;
        d_c_reg     <= c_c_reg;

        e_fmag_reg  <= e_fmag_next;
        e_fneg_reg  <= e_fneg_next;
        e_b_reg     <= d_b_reg;
        e_c_reg     <= d_c_reg;

        f_ph_reg    <= f_ph_next;
        f_pl_reg    <= f_pl_next;
        f_tneg_reg  <= e_fneg_reg ^ e_c_reg[31];
        f_b_reg     <= e_b_reg;

        g_tmag_reg  <= g_tmag_next;
        g_tneg_reg  <= f_tneg_reg;
        g_b_reg     <= f_b_reg;

        h_v_reg     <= h_v_next;
        h_b_reg     <= g_b_reg;

        i_y_reg     <= i_y_next;
        i_rom_reg   <= i_rom_next;
        i_sh_reg    <= h_v_reg[52:46];
        i_b_reg     <= h_b_reg;

        j_y_reg     <= i_y_reg;
        j_yy_reg    <= j_yy_next;
        j_rom_reg   <= i_rom_reg;
        j_sh_reg    <= i_sh_reg;
        j_b_reg     <= i_b_reg;

        k_p_reg     <= k_p_next;
        k_rom_reg   <= j_rom_reg;
        k_sh_reg    <= j_sh_reg;
        k_b_reg     <= j_b_reg;

        l_m_reg     <= l_m_next;
        l_sh_reg    <= k_sh_reg;
        l_b_reg     <= k_b_reg;

        m_e_reg     <= m_e_next;
        m_b_reg     <= l_b_reg;

        n_ph_reg    <= n_ph_next;
        n_pl_reg    <= n_pl_next;

        o_term_reg  <= o_term_next;
    end

    assign out_valid = vld_reg[NST-1];
    assign term = o_term_reg;
    assign active = |vld_reg;

endmodule

// ===== design/gmd_div.sv =====
// radix-2 restoring divider, 64-bit dividend by a small count, one bit per cycle
// depends on gmd_pkg
module gmd_div
    import gmd_pkg::*;
#(
    parameter int KW = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   dividend,
    input  logic [KW-1:0] divisor,
    output logic          done,
    output logic [63:0]   quotient
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [63:0]   num_reg, num_next;
    logic [KW-1:0] rem_reg, rem_next;
    logic [KW-1:0] dvs_reg;
    logic [KW:0]   trial;
    logic          ge;

    always_comb
    begin
        trial = {rem_reg, num_reg[63]};
        ge = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            num_next = dividend;
            rem_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? KW'(trial - {1'b0, dvs_reg}) : KW'(trial);
            num_next = {num_reg[62:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done = done_reg;
    assign quotient = num_reg;

endmodule

// ===== design/gaussian_mixture_density_core.sv =====
// equal-weight bivariate gaussian mixture density, q16.16
// a load is written into its slot in the cycle after start; the done transfer of an evaluate comes
// after the chain rotates (one slot per cycle), the 15-stage term pipeline drains and the 64-step divide ends
// throughput: one evaluate at a time, busy high until done; the receiver cannot stall
// reset: control state and component_count (to 1) clear at once; slots hold garbage until loaded
// depends on gmd_pkg, gmd_cell, gmd_term, gmd_div and assert_macros.svh
`include "assert_macros.svh"

module gaussian_mixture_density_core
    import gmd_pkg::*;
#(
    parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF,
    parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [3:0]         slot,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] mean_x,
    input  logic signed [31:0] mean_y,
    input  logic [31:0]        inv_sigma_x,
    input  logic [31:0]        inv_sigma_y,
    input  logic signed [16:0] correlation,
    input  logic [31:0]        peak_scale,
    input  logic signed [31:0] exponent_scale,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata,
    output logic               done,
    output logic [31:0]        density,
    output logic               saturated
);

    localparam int KW = $clog2(MAX_COMPONENTS + 1);
    localparam int IW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

    state_t        state_reg, state_next;
    logic [IW-1:0] step_reg, step_next;
    logic [4:0]    count_reg;
    logic [31:0]   px_reg, py_reg;
    logic [63:0]   acc_reg;
    logic          done_reg;
    logic [31:0]   density_reg;
    logic          saturated_reg;

    logic          accept, eval_go, load_go;
    logic          shift, issue_valid, div_start;
    logic [KW-1:0] k_eff;
    comp_t         ring [MAX_COMPONENTS];
    comp_t         load_data;
    logic          term_valid, term_active;
    logic [63:0]   term;
    logic [64:0]   acc_sum;
    logic          div_done;
    logic [63:0]   quotient;

    assign accept  = start && !busy;
    assign eval_go = accept && (operation == OP_EVAL);
    assign load_go = accept && (operation == OP_LOAD) && (int'(slot) < MAX_COMPONENTS);

    always_comb
    begin
        if (count_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(count_reg) > MAX_COMPONENTS)
        begin
            k_eff = KW'(MAX_COMPONENTS);
        end
        else
        begin
            k_eff = KW'(count_reg);
        end
    end

    assign load_data = '{mean_x: mean_x, mean_y: mean_y,
                         inv_sigma_x: inv_sigma_x, inv_sigma_y: inv_sigma_y,
                         correlation: correlation, peak_scale: peak_scale,
                         exponent_scale: exponent_scale};

    // ring rotates one full turn per evaluate, so slots are back home afterwards
    for (genvar g = 0; g < MAX_COMPONENTS; g++)
    begin : g_chain
        gmd_cell u_cell (
            .clk       (clk),
            .shift     (shift),
            .from_next (ring[(g + 1) % MAX_COMPONENTS]),
            .load      (load_go && (int'(slot) == g)),
            .load_data (load_data),
            .comp      (ring[g])
        );
    end

    gmd_term #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue_valid),
        .comp      (ring[0]),
        .pos_x     (px_reg),
        .pos_y     (py_reg),
        .out_valid (term_valid),
        .term      (term),
        .active    (term_active)
    );

    gmd_div #(
        .KW (KW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (k_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (eval_go)
                begin
                    state_next = ST_ISSUE;
                    step_next = '0;
                end
            end
            ST_ISSUE:
            begin
                step_next = step_reg + IW'(1);
                if (step_reg == IW'(MAX_COMPONENTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!term_active)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        shift = 1'b0;
        issue_valid = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_ISSUE:
            begin
                shift = 1'b1;
                issue_valid = (int'(step_reg) < int'(k_eff));
            end
            ST_DRAIN:
            begin
                div_start = !term_active;
            end
            ST_DIVIDE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign acc_sum = {1'b0, acc_reg} + {1'b0, term};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            count_reg <= 5'd1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= div_done;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_go)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            acc_reg <= '0;
        end
        else if (term_valid)
        begin
            acc_reg <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
        end
        if (div_done)
        begin
            density_reg <= (|quotient[63:32]) ? 32'hFFFFFFFF : quotient[31:0];
            saturated_reg <= |quotient[63:32];
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign density = density_reg;
    assign saturated = saturated_reg;

    `GMD_ASSERT_IMP(a_done_after_busy, clk, rst_n, done, $past(busy), "done without a prior evaluate")
    `GMD_ASSERT_NXT(a_eval_sets_busy, clk, rst_n, eval_go, busy, "evaluate did not raise busy")
    `GMD_ASSERT_IMP(a_term_in_window, clk, rst_n, term_valid,
        (state_reg == ST_ISSUE || state_reg == ST_DRAIN), "term arrived outside evaluation")
    `GMD_ASSERT_IMP(a_no_issue_when_idle, clk, rst_n, !busy, !issue_valid && !shift,
        "chain moved while idle")

endmodule
